// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/esc_pkg.sv =====
package esc_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned DoeW   = 18;

  // floor(2^K / D), K = width of the dividend; quotient is low by at most one.
  localparam logic [26:0] Recip60W32  = 27'd71582788;
  localparam logic [21:0] Recip60W27  = 22'd2236962;
  localparam logic [16:0] Recip24W21  = 17'd87381;
  localparam logic [7:0]  Recip1460   = 8'd179;
  localparam logic [2:0]  Recip36524  = 3'd7;
  localparam logic [9:0]  Recip365    = 10'd718;

  // Days from 1600-03-01 to 1970-01-01, and one 400-year cycle.
  localparam logic [DoeW-1:0] DaysToEraBase = 18'd135080;
  localparam logic [DoeW-1:0] DaysPerEra    = 18'd146097;
  localparam logic [DoeW-1:0] EraLastDay    = 18'd146096;
  localparam logic [YearW-1:0] BaseYear     = 12'd1600;
  localparam logic [YearW-1:0] YearsPerEra  = 12'd400;

  // March-based month index of January.
  localparam logic [3:0] MpJanuary = 4'd10;
  localparam logic [3:0] MpLast    = 4'd11;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } esc_hms_t;

  typedef struct packed {
    esc_hms_t         hms;
    logic [DaysW-1:0] days;
  } esc_split_t;

  // First day-of-year of each month in a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/esc_intf.sv =====
interface esc_in_if import esc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source(output valid, output epoch_seconds, input ready);
  modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if import esc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;

  modport source(output valid, output year, output month, output day_of_month,
                 output hour, output minute, output second, input ready);
  modport sink(input valid, input year, input month, input day_of_month,
               input hour, input minute, input second, output ready);
endinterface

// ===== src/esc_time_split.sv =====
// Seconds -> second, minute, hour, day count. Six stages: multiply, correct, x3.
module esc_time_split import esc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  logic [EpochW-1:0] epoch_seconds_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output esc_split_t        split_o
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || rdy_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? vld_i : vld_q[k-1];
        end
      end
    end
  end

  assign rdy_o = en[0];
  assign vld_o = vld_q[NStg-1];

  // stage 1: t * floor(2^32/60)
  logic [58:0]       prod1;
  logic [EpochW-1:0] t1_q;
  logic [26:0]       qa1_q;
  assign prod1 = 59'(epoch_seconds_i) * 59'(Recip60W32);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t1_q  <= epoch_seconds_i;
      qa1_q <= prod1[58:32];
    end
  end

  // stage 2: fix quotient, remainder is seconds
  logic [6:0]      rem2;
  logic            fix2;
  logic [SecW-1:0] sec2_q;
  logic [26:0]     mins2_q;
  assign rem2 = t1_q[6:0] - 7'(qa1_q[6:0] * 7'd60);
  assign fix2 = rem2 >= 7'd60;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sec2_q  <= fix2 ? 6'(rem2 - 7'd60) : rem2[5:0];
      mins2_q <= qa1_q + 27'(fix2);
    end
  end

  // stage 3: minutes * floor(2^27/60)
  logic [48:0]     prod3;
  logic [SecW-1:0] sec3_q;
  logic [26:0]     mins3_q;
  logic [20:0]     qb3_q;
  assign prod3 = 49'(mins2_q) * 49'(Recip60W27);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sec3_q  <= sec2_q;
      mins3_q <= mins2_q;
      qb3_q   <= prod3[47:27];
    end
  end

  // stage 4
  logic [6:0]      rem4;
  logic            fix4;
  logic [SecW-1:0] sec4_q;
  logic [MinW-1:0] min4_q;
  logic [20:0]     hours4_q;
  assign rem4 = mins3_q[6:0] - 7'(qb3_q[6:0] * 7'd60);
  assign fix4 = rem4 >= 7'd60;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sec4_q   <= sec3_q;
      min4_q   <= fix4 ? 6'(rem4 - 7'd60) : rem4[5:0];
      hours4_q <= qb3_q + 21'(fix4);
    end
  end

  // stage 5: hours * floor(2^21/24)
  logic [37:0]      prod5;
  logic [SecW-1:0]  sec5_q;
  logic [MinW-1:0]  min5_q;
  logic [20:0]      hours5_q;
  logic [DaysW-1:0] qc5_q;
  assign prod5 = 38'(hours4_q) * 38'(Recip24W21);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sec5_q   <= sec4_q;
      min5_q   <= min4_q;
      hours5_q <= hours4_q;
      qc5_q    <= prod5[36:21];
    end
  end

  // stage 6
  logic [5:0] rem6;
  logic       fix6;
  esc_split_t split6_q;
  assign rem6 = hours5_q[5:0] - 6'(qc5_q[5:0] * 6'd24);
  assign fix6 = rem6 >= 6'd24;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      split6_q.hms.second <= sec5_q;
      split6_q.hms.minute <= min5_q;
      split6_q.hms.hour   <= fix6 ? 5'(rem6 - 6'd24) : rem6[4:0];
      split6_q.days       <= qc5_q + DaysW'(fix6);
    end
  end

  assign split_o = split6_q;

endmodule

// ===== src/esc_day_to_date.sv =====
// Day count -> year, month, day. Civil-date split on 400-year cycles, 10 stages.
module esc_day_to_date import esc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  esc_split_t        split_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_of_month_o,
  output esc_hms_t          hms_o
);

  localparam int unsigned NStg = 10;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || rdy_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= (k == 0) ? vld_i : vld_q[k-1];
        end
      end
    end
  end

  assign rdy_o = en[0];
  assign vld_o = vld_q[NStg-1];

  // time of day rides along
  esc_hms_t hms_q [NStg];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        hms_q[k] <= (k == 0) ? split_i.hms : hms_q[k-1];
      end
    end
  end

  assign hms_o = hms_q[NStg-1];

  // s0: rebase to 1600-03-01, split off the era
  logic [DoeW-1:0] dfull;
  logic            era_c;
  logic            era0_q;
  logic [DoeW-1:0] doe0_q;
  assign dfull = DoeW'(split_i.days) + DaysToEraBase;
  assign era_c = dfull >= DaysPerEra;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      era0_q <= era_c;
      doe0_q <= era_c ? dfull - DaysPerEra : dfull;
    end
  end

  // s1: doe/1460 and doe/36524 estimates
  logic [25:0]     p1460;
  logic [20:0]     p36524;
  logic            era1_q;
  logic [DoeW-1:0] doe1_q;
  logic [6:0]      q1460_1_q;
  logic [2:0]      q36524_1_q;
  logic            last1_q;
  assign p1460  = 26'(doe0_q) * 26'(Recip1460);
  assign p36524 = 21'(doe0_q) * 21'(Recip36524);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      era1_q     <= era0_q;
      doe1_q     <= doe0_q;
      q1460_1_q  <= p1460[24:18];
      q36524_1_q <= p36524[20:18];
      last1_q    <= doe0_q == EraLastDay;
    end
  end

  // s2: fix both
  logic [11:0]     r1460;
  logic [16:0]     r36524;
  logic            era2_q;
  logic [DoeW-1:0] doe2_q;
  logic [6:0]      q1460_2_q;
  logic [2:0]      q36524_2_q;
  logic            last2_q;
  assign r1460  = doe1_q[11:0] - 12'(12'(q1460_1_q) * 12'd1460);
  assign r36524 = doe1_q[16:0] - 17'(17'(q36524_1_q) * 17'd36524);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      era2_q     <= era1_q;
      doe2_q     <= doe1_q;
      q1460_2_q  <= q1460_1_q + 7'(r1460 >= 12'd1460);
      q36524_2_q <= q36524_1_q + 3'(r36524 >= 17'd36524);
      last2_q    <= last1_q;
    end
  end

  // s3: leap-free day count
  logic            era3_q;
  logic [DoeW-1:0] doe3_q;
  logic [DoeW-1:0] n3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      era3_q <= era2_q;
      doe3_q <= doe2_q;
      n3_q   <= doe2_q - DoeW'(q1460_2_q) + DoeW'(q36524_2_q) - DoeW'(last2_q);
    end
  end

  // s4: n/365 estimate
  logic [27:0]     p365;
  logic            era4_q;
  logic [DoeW-1:0] doe4_q;
  logic [DoeW-1:0] n4_q;
  logic [8:0]      q365_4_q;
  assign p365 = 28'(n3_q) * 28'(Recip365);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      era4_q   <= era3_q;
      doe4_q   <= doe3_q;
      n4_q     <= n3_q;
      q365_4_q <= p365[26:18];
    end
  end

  // s5: year of era
  logic [9:0]      r365;
  logic            era5_q;
  logic [DoeW-1:0] doe5_q;
  logic [8:0]      yoe5_q;
  assign r365 = n4_q[9:0] - 10'(10'(q365_4_q) * 10'd365);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      era5_q <= era4_q;
      doe5_q <= doe4_q;
      yoe5_q <= q365_4_q + 9'(r365 >= 10'd365);
    end
  end

  // s6: first day of that year within the era; yoe/100 is exact as (yoe*41)>>12 below 400
  logic [13:0]      p100;
  logic [DoeW-1:0]  doe6_q;
  logic [DoeW-1:0]  ys6_q;
  logic [YearW-1:0] yb6_q;
  assign p100 = 14'(yoe5_q) * 14'd41;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      doe6_q <= doe5_q;
      ys6_q  <= DoeW'(yoe5_q) * DoeW'(365) + DoeW'(yoe5_q[8:2]) - DoeW'(p100[13:12]);
      yb6_q  <= BaseYear + (era5_q ? YearsPerEra : '0) + YearW'(yoe5_q);
    end
  end

  // s7: day of March-based year
  logic [DoeW-1:0]  doy_full;
  logic [8:0]       doy7_q;
  logic [YearW-1:0] yb7_q;
  assign doy_full = doe6_q - ys6_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      doy7_q <= doy_full[8:0];
      yb7_q  <= yb6_q;
    end
  end

  // s8: month by compare against month starts
  logic [3:0]       mp_c;
  logic [8:0]       doy8_q;
  logic [3:0]       mp8_q;
  logic [YearW-1:0] yb8_q;

  always_comb begin
    mp_c = '0;
    for (int i = 1; i <= int'(MpLast); i++) begin
      if (doy7_q >= month_start(4'(i))) begin
        mp_c = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      doy8_q <= doy7_q;
      mp8_q  <= mp_c;
      yb8_q  <= yb7_q;
    end
  end

  // s9: output register
  logic              jan_feb;
  logic [8:0]        dom_c;
  logic [YearW-1:0]  year9_q;
  logic [MonthW-1:0] month9_q;
  logic [DayW-1:0]   dom9_q;
  assign jan_feb = mp8_q >= MpJanuary;
  assign dom_c   = doy8_q - month_start(mp8_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      year9_q  <= yb8_q + YearW'(jan_feb);
      month9_q <= jan_feb ? mp8_q - 4'd9 : mp8_q + 4'd3;
      dom9_q   <= dom_c[4:0];
    end
  end

  assign year_o         = year9_q;
  assign month_o        = month9_q;
  assign day_of_month_o = dom9_q;

endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into a
// Gregorian date and time of day (year 1970..2106, month 1..12, day 1..31,
// hour, minute, second), using the full leap rule including the century and
// 400-year exceptions. Throughput is one beat per clock unless the output stalls;
// the work is a constant-divide pipeline: six stages split off seconds, minutes
// and hours (each divide is a reciprocal multiply, then a one-step fix), and
// ten stages turn the day count into a date on a 400-year cycle. Each stage
// holds its own valid bit, so under back-pressure empty stages close up and
// the input keeps taking beats until the pipe is full. No state besides the
// pipeline; reset only clears valid bits.
`include "assert_macros.svh"

module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);

  // seconds -> time of day + day count
  logic       split_vld;
  logic       split_rdy;
  esc_split_t split;

  esc_time_split u_time_split (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (in_i.valid),
    .rdy_o           (in_i.ready),
    .epoch_seconds_i (in_i.epoch_seconds),
    .vld_o           (split_vld),
    .rdy_i           (split_rdy),
    .split_o         (split)
  );

  // day count -> year/month/day; last stage is the output register
  esc_hms_t hms;

  esc_day_to_date u_day_to_date (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (split_vld),
    .rdy_o          (split_rdy),
    .split_i        (split),
    .vld_o          (out_o.valid),
    .rdy_i          (out_o.ready),
    .year_o         (out_o.year),
    .month_o        (out_o.month),
    .day_of_month_o (out_o.day_of_month),
    .hms_o          (hms)
  );

  assign out_o.hour   = hms.hour;
  assign out_o.minute = hms.minute;
  assign out_o.second = hms.second;

  // Range checks on every result beat: a slip in a divide fix may show here.
  `ESC_ASSERT_IMP(a_time_range, out_o.valid, (out_o.hour < 5'd24) && (out_o.minute < 6'd60) && (out_o.second < 6'd60), "time of day out of range")
  `ESC_ASSERT_IMP(a_date_range, out_o.valid, (out_o.year >= 12'd1970) && (out_o.year <= 12'd2106) && (out_o.month >= 4'd1) && (out_o.month <= 4'd12) && (out_o.day_of_month >= 5'd1), "date out of range")
  `ESC_ASSERT_IMP(a_month_len, out_o.valid, ((out_o.month != 4'd2) || (out_o.day_of_month <= 5'd29)) && ((out_o.month != 4'd4 && out_o.month != 4'd6 && out_o.month != 4'd9 && out_o.month != 4'd11) || (out_o.day_of_month <= 5'd30)), "day past end of month")

endmodule
